>>> rtl/mcc_pkg.sv
`timescale 1ns / 1ps
// mcc_pkg: shared constants, codes and transaction types of the 3x3 multichannel convolution
// used by every rtl file of the block, no dependencies
package mcc_pkg;

	localparam int KERNEL          = 3;
	localparam int CHANNELS        = 3;
	localparam int NUM_WEIGHTS     = CHANNELS * KERNEL * KERNEL;
	localparam int WEIGHT_BITS     = 16;
	localparam int WIDX_BITS       = 5;
	localparam int SUM_BITS        = 38;
	localparam int OUT_COL_BITS    = 6;
	localparam int OUT_ROW_BITS    = 16;
	localparam int IMG_W_BITS      = 7;
	localparam int IMG_H_BITS      = 16;
	localparam int CFG_IDX_BITS    = 1;
	localparam int CFG_DATA_BITS   = 16;
	localparam int MIN_DIM         = 3;
	localparam int RST_IMAGE_WIDTH  = 32;
	localparam int RST_IMAGE_HEIGHT = 32;

	// defaults for the top level parameters
	localparam int DEF_MAX_WIDTH   = 64;
	localparam int DEF_SAMPLE_BITS = 16;

	// result queue depth and its count width
	localparam int OUT_DEPTH      = 8;
	localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_BITS   = $clog2(OUT_DEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// input function codes
	localparam logic FUNC_WEIGHT = 1'b0;
	localparam logic FUNC_PIXEL  = 1'b1;

	// per-pixel tag that travels beside the arithmetic
	typedef struct packed {
		logic                    res;
		logic                    last;
		logic [OUT_COL_BITS-1:0] col;
		logic [OUT_ROW_BITS-1:0] row;
	} tag_t;

	// weight load travelling down the pipe to the weight registers
	typedef struct packed {
		logic                          en;
		logic [WIDX_BITS-1:0]          idx;
		logic signed [WEIGHT_BITS-1:0] val;
	} wload_t;

	typedef struct packed {
		logic signed [SUM_BITS-1:0] sum;
		tag_t                       tag;
	} result_t;

endpackage

>>> rtl/mcc_line_store.sv
`timescale 1ns / 1ps
// mcc_line_store: synchronous memory holding the two previous image rows per column
// one read and one write port, fill mark for entries never written; uses mcc_pkg
module mcc_line_store #(
	parameter int MAX_WIDTH = mcc_pkg::DEF_MAX_WIDTH,
	parameter int ROW_BITS  = 2 * mcc_pkg::CHANNELS * mcc_pkg::DEF_SAMPLE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	output logic [ROW_BITS-1:0]          rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  logic [ROW_BITS-1:0]          wr_data
);
	import mcc_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic [ROW_BITS-1:0] mem_q [MAX_WIDTH];
	logic [ROW_BITS-1:0] rd_raw_q;
	logic [AW:0]         fill_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	// columns are written from zero upward, so the written entries are always the
	// ones below the fill mark; an entry at or above it reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en && ({1'b0, wr_addr} >= fill_q)) begin
				fill_q <= {1'b0, wr_addr} + 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= ({1'b0, rd_addr} < fill_q);
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

>>> rtl/mcc_mac.sv
`timescale 1ns / 1ps
// mcc_mac: 3x3x3 window registers, weight registers, 27 multipliers and a registered adder tree
// uses mcc_pkg
module mcc_mac #(
	parameter int SAMPLE_BITS = mcc_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     pix_s1,
	input  logic [mcc_pkg::CHANNELS*SAMPLE_BITS-1:0] px_s1,
	input  logic [mcc_pkg::CHANNELS*SAMPLE_BITS-1:0] line_a,
	input  logic [mcc_pkg::CHANNELS*SAMPLE_BITS-1:0] line_b,
	input  mcc_pkg::tag_t                            tag_s1,
	input  mcc_pkg::wload_t                          wl_s1,
	output mcc_pkg::result_t                         res_s6
);
	import mcc_pkg::*;

	localparam int PW  = SAMPLE_BITS + WEIGHT_BITS;
	localparam int SW4 = PW + 2;
	localparam int SW5 = PW + 4;
	localparam int SW6 = PW + 6;

	logic signed [SAMPLE_BITS-1:0] win_q [KERNEL][KERNEL][CHANNELS];
	logic signed [WEIGHT_BITS-1:0] wt_q [NUM_WEIGHTS];
	logic signed [PW-1:0]          prod_s3 [NUM_WEIGHTS];
	logic signed [SW4-1:0]         sum_s4 [NUM_WEIGHTS/3];
	logic signed [SW5-1:0]         sum_s5 [NUM_WEIGHTS/9];
	logic signed [SW6-1:0]         sum_s6;
	tag_t   tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	wload_t wl_s2;

	// window shift: oldest row from line b, middle from line a, newest is the pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KERNEL; i++)
				for (int j = 0; j < KERNEL; j++)
					for (int ch = 0; ch < CHANNELS; ch++)
						win_q[i][j][ch] <= '0;
		end else if (pix_s1) begin
			for (int i = 0; i < KERNEL; i++)
				for (int j = 0; j < KERNEL - 1; j++)
					for (int ch = 0; ch < CHANNELS; ch++)
						win_q[i][j][ch] <= win_q[i][j+1][ch];
			for (int ch = 0; ch < CHANNELS; ch++) begin
				win_q[0][KERNEL-1][ch] <= line_b[ch*SAMPLE_BITS +: SAMPLE_BITS];
				win_q[1][KERNEL-1][ch] <= line_a[ch*SAMPLE_BITS +: SAMPLE_BITS];
				win_q[2][KERNEL-1][ch] <= px_s1[ch*SAMPLE_BITS +: SAMPLE_BITS];
			end
		end
	end

	// tags and weight loads; control bits reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			wl_s2  <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			wl_s2  <= wl_s1;
		end
	end

	// weights change in the same stage that reads them, so order with pixels is kept
	always_ff @(posedge clk) begin
		if (wl_s2.en && (wl_s2.idx < WIDX_BITS'(NUM_WEIGHTS))) begin
			wt_q[wl_s2.idx] <= wl_s2.val;
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < CHANNELS; ch++)
			for (int i = 0; i < KERNEL; i++)
				for (int j = 0; j < KERNEL; j++)
					prod_s3[ch*KERNEL*KERNEL + i*KERNEL + j] <=
						win_q[i][j][ch] * wt_q[ch*KERNEL*KERNEL + i*KERNEL + j];
		for (int g = 0; g < NUM_WEIGHTS/3; g++)
			sum_s4[g] <= SW4'(prod_s3[3*g]) + SW4'(prod_s3[3*g+1]) + SW4'(prod_s3[3*g+2]);
		for (int g = 0; g < NUM_WEIGHTS/9; g++)
			sum_s5[g] <= SW5'(sum_s4[3*g]) + SW5'(sum_s4[3*g+1]) + SW5'(sum_s4[3*g+2]);
		sum_s6 <= SW6'(sum_s5[0]) + SW6'(sum_s5[1]) + SW6'(sum_s5[2]);
	end

	assign res_s6.sum = SUM_BITS'(sum_s6);
	assign res_s6.tag = tag_s6;

endmodule

>>> rtl/mcc_out_fifo.sv
`timescale 1ns / 1ps
// mcc_out_fifo: result queue between the adder tree and the output channel
// uses mcc_pkg
module mcc_out_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  mcc_pkg::result_t               push_data,
	input  logic                           out_ready,
	output logic                           out_valid,
	output mcc_pkg::result_t               out_data,
	output logic [mcc_pkg::OUT_CNT_BITS-1:0] count
);
	import mcc_pkg::*;

	result_t                 buf_q [OUT_DEPTH];
	logic [OUT_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUT_CNT_BITS-1:0] cnt_q;
	logic                    pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = buf_q[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + OUT_CNT_BITS'(push) - OUT_CNT_BITS'(pop);
		end
	end

endmodule

>>> rtl/multichannel_conv3x3_valid_top.sv
`timescale 1ns / 1ps
// multichannel_conv3x3_valid_top: streaming 3x3 convolution over three channels, valid region only
// instantiates mcc_line_store, mcc_mac and mcc_out_fifo; uses mcc_pkg
//
// Streaming 3x3 correlation over three-channel Q1.15 pixels in raster order. Each input
// transaction either loads one filter weight (func = 0, index channel*9 + row*3 + column;
// indexes above 26 are dropped) or delivers one pixel (func = 1). One input transaction is
// taken every clock cycle for as long as out_ready keeps up; the rate is set by the line
// store, a single-port-read / single-port-write memory touched once per pixel, and by the
// 27 multipliers that work in parallel on the window. A taken pixel passes through the
// line store read, the window registers, the multiplier registers, the adder tree
// registers and the write into the output queue before its result appears on the output.
// Up to eight results can wait in the output queue; in_ready drops only when the
// queue plus the results still in the pipe would exceed it. Only pixels at row >= 2 and
// column >= 2 give a result, with the exact 38-bit sum and the output coordinates;
// frame_last marks the last pixel of the frame. Weights must be loaded before pixels use
// them. image_width is clamped to [3, MAX_WIDTH] and image_height to at least 3 when
// written. The user must write registers only while the block is idle; the block itself
// does not enforce this. A register write is always taken at once.
module multichannel_conv3x3_valid_top #(
	parameter int MAX_WIDTH   = mcc_pkg::DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = mcc_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 func,
	input  logic [mcc_pkg::WIDX_BITS-1:0]        weight_index,
	input  logic signed [mcc_pkg::WEIGHT_BITS-1:0] weight_value,
	input  logic signed [SAMPLE_BITS-1:0]        sample_ch0,
	input  logic signed [SAMPLE_BITS-1:0]        sample_ch1,
	input  logic signed [SAMPLE_BITS-1:0]        sample_ch2,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [mcc_pkg::SUM_BITS-1:0]  conv_sum,
	output logic [mcc_pkg::OUT_COL_BITS-1:0]     out_col,
	output logic [mcc_pkg::OUT_ROW_BITS-1:0]     out_row,
	output logic                                 frame_last,
	// configuration channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mcc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [mcc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import mcc_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int LB  = CHANNELS * SAMPLE_BITS;
	localparam int WE  = ($clog2(MAX_WIDTH + 1) > IMG_W_BITS) ? $clog2(MAX_WIDTH + 1) : IMG_W_BITS;
	localparam int RST_W_LAST =
		((RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH) - 1;
	localparam int RST_H_LAST = RST_IMAGE_HEIGHT - 1;

	// ---------------- configuration ----------------
	// last column and last row are kept already clamped
	logic [CW-1:0]         w_last_q;
	logic [IMG_H_BITS-1:0] h_last_q;
	logic [WE-1:0]         w_ext, w_eff;
	logic [IMG_H_BITS-1:0] h_eff;
	logic                  cfg_acc;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_comb begin
		w_ext = WE'(cfg_data[IMG_W_BITS-1:0]);
		priority if (w_ext < WE'(MIN_DIM)) begin
			w_eff = WE'(MIN_DIM);
		end else if (w_ext > WE'(MAX_WIDTH)) begin
			w_eff = WE'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		h_eff = (cfg_data[IMG_H_BITS-1:0] < IMG_H_BITS'(MIN_DIM)) ?
			IMG_H_BITS'(MIN_DIM) : cfg_data[IMG_H_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= CW'(RST_W_LAST);
			h_last_q <= IMG_H_BITS'(RST_H_LAST);
		end else if (cfg_acc) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  w_last_q <= CW'(w_eff - WE'(1));
				REG_IMAGE_HEIGHT: h_last_q <= h_eff - IMG_H_BITS'(1);
				default: ;
			endcase
		end
	end

	// ---------------- raster position ----------------
	logic [CW-1:0]         col_q;
	logic [IMG_H_BITS-1:0] row_q;
	logic                  in_acc, pix_acc, col_end, row_end, res_here;

	assign in_acc   = in_valid && in_ready;
	assign pix_acc  = in_acc && (func == FUNC_PIXEL);
	// at-or-beyond tests so a narrowed frame wraps on the next pixel
	assign col_end  = (col_q >= w_last_q);
	assign row_end  = (row_q >= h_last_q);
	assign res_here = (row_q >= IMG_H_BITS'(KERNEL - 1)) && (col_q >= CW'(KERNEL - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ---------------- stage 1: line store read in flight ----------------
	logic          pix_s1;
	logic [CW-1:0] addr_s1;
	logic [LB-1:0] px_s1;
	tag_t          tag_s1;
	wload_t        wl_s1;
	logic [2*LB-1:0] ls_rd_data;
	logic [2*LB-1:0] ls_wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= 1'b0;
			tag_s1 <= '0;
			wl_s1  <= '0;
		end else begin
			pix_s1     <= pix_acc;
			tag_s1.res <= pix_acc && res_here;
			tag_s1.last <= row_end && col_end;
			tag_s1.col <= OUT_COL_BITS'(col_q - CW'(KERNEL - 1));
			tag_s1.row <= row_q - IMG_H_BITS'(KERNEL - 1);
			wl_s1.en   <= in_acc && (func == FUNC_WEIGHT);
			wl_s1.idx  <= weight_index;
			wl_s1.val  <= weight_value;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			addr_s1 <= col_q;
			px_s1   <= {sample_ch2, sample_ch1, sample_ch0};
		end
	end

	// line entry: upper half is the previous row, lower half the row before that;
	// write-back ages the previous row and stores the new pixel. a width of at least
	// three keeps the read of the next pixels off the entry being written back
	assign ls_wr_data = {px_s1, ls_rd_data[2*LB-1:LB]};

	mcc_line_store #(
		.MAX_WIDTH (MAX_WIDTH),
		.ROW_BITS  (2 * LB)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (pix_acc),
		.rd_addr (col_q),
		.rd_data (ls_rd_data),
		.wr_en   (pix_s1),
		.wr_addr (addr_s1),
		.wr_data (ls_wr_data)
	);

	// ---------------- window, multipliers, adder tree ----------------
	result_t res_s6;

	mcc_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_s1 (pix_s1),
		.px_s1  (px_s1),
		.line_a (ls_rd_data[2*LB-1:LB]),
		.line_b (ls_rd_data[LB-1:0]),
		.tag_s1 (tag_s1),
		.wl_s1  (wl_s1),
		.res_s6 (res_s6)
	);

	// ---------------- output queue and credit ----------------
	result_t                 q_data;
	logic [OUT_CNT_BITS-1:0] q_count;
	logic [OUT_CNT_BITS-1:0] inflight_q;
	logic                    push;

	assign push = res_s6.tag.res;

	mcc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res_s6),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (q_data),
		.count     (q_count)
	);

	// results still in the pipe, so the queue can never overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + OUT_CNT_BITS'(pix_acc && res_here)
				- OUT_CNT_BITS'(push);
		end
	end

	assign in_ready = (({1'b0, q_count} + {1'b0, inflight_q}) < (OUT_CNT_BITS + 1)'(OUT_DEPTH));

	assign conv_sum   = q_data.sum;
	assign out_col    = q_data.tag.col;
	assign out_row    = q_data.tag.row;
	assign frame_last = q_data.tag.last;

endmodule

>>> rtl/mcc_checker.sv
`timescale 1ns / 1ps
// mcc_checker: port-level assertions for the convolution top level, bound to it below
// uses mcc_pkg widths
module mcc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                func,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [mcc_pkg::SUM_BITS-1:0] conv_sum,
	input logic [mcc_pkg::OUT_COL_BITS-1:0]    out_col,
	input logic [mcc_pkg::OUT_ROW_BITS-1:0]    out_row,
	input logic                                frame_last
);
	import mcc_pkg::*;

	// a waiting result keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(conv_sum) && $stable(out_col)
			&& $stable(out_row) && $stable(frame_last))
		else $error("output transaction changed while stalled");

	// a result first seen at an edge comes from a pixel taken earlier
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (func == FUNC_PIXEL), 7))
		else $error("result without a matching pixel transaction");

	// back-pressure only when results are actually queued
	a_ready_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty output queue");

endmodule

bind multichannel_conv3x3_valid_top mcc_checker u_mcc_checker (.*);

>>> test/mcc_conv_checker.sv
`timescale 1ns / 1ps
// mcc_conv_checker: passive checker for the 3x3 multichannel convolution, keeps its own
// weights, line stores and window, predicts each result and compares it; uses mcc_pkg
module mcc_conv_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic                                   func,
	input  logic [mcc_pkg::WIDX_BITS-1:0]          weight_index,
	input  logic signed [mcc_pkg::WEIGHT_BITS-1:0] weight_value,
	input  logic signed [15:0]                     sample_ch0,
	input  logic signed [15:0]                     sample_ch1,
	input  logic signed [15:0]                     sample_ch2,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic signed [mcc_pkg::SUM_BITS-1:0]    conv_sum,
	input  logic [mcc_pkg::OUT_COL_BITS-1:0]       out_col,
	input  logic [mcc_pkg::OUT_ROW_BITS-1:0]       out_row,
	input  logic                                   frame_last,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [mcc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [mcc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                                   end_check,
	output int                                     errors,
	output int                                     pending
);

	localparam int LINE_LEN = mcc_pkg::DEF_MAX_WIDTH;

	typedef struct packed {
		logic signed [mcc_pkg::SUM_BITS-1:0] sum;
		logic [mcc_pkg::OUT_COL_BITS-1:0]    col;
		logic [mcc_pkg::OUT_ROW_BITS-1:0]    row;
		logic                                last;
	} conv_out_t;

	logic signed [15:0] coeff [mcc_pkg::NUM_WEIGHTS];
	logic signed [15:0] row_prev [LINE_LEN][3];
	logic signed [15:0] row_prev2 [LINE_LEN][3];
	logic signed [15:0] win [3][3][3];
	int                 col_pos;
	int                 row_pos;
	logic [mcc_pkg::IMG_W_BITS-1:0] width_reg;
	logic [mcc_pkg::IMG_H_BITS-1:0] height_reg;
	conv_out_t          owed_sums [$];
	bit                 leftover_done;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic clear_model();
		for (int k = 0; k < mcc_pkg::NUM_WEIGHTS; k++)
			coeff[k] = '0;
		for (int x = 0; x < LINE_LEN; x++)
			for (int ch = 0; ch < 3; ch++) begin
				row_prev[x][ch]  = '0;
				row_prev2[x][ch] = '0;
			end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				for (int ch = 0; ch < 3; ch++)
					win[i][j][ch] = '0;
		col_pos       = 0;
		row_pos       = 0;
		width_reg     = mcc_pkg::RST_IMAGE_WIDTH;
		height_reg    = mcc_pkg::RST_IMAGE_HEIGHT;
		owed_sums.delete();
		leftover_done = 1'b0;
		errors        = 0;
	endtask

	// one pixel through the line stores and window, owes a sum inside the valid region
	task automatic slide_window(input logic signed [15:0] s0, s1, s2);
		int                 w;
		int                 h;
		int                 c;
		int                 r;
		logic signed [15:0] px [3];
		longint             acc;
		conv_out_t          res;
		px[0] = s0;
		px[1] = s1;
		px[2] = s2;
		w = width_reg;
		if (w < mcc_pkg::MIN_DIM) w = mcc_pkg::MIN_DIM;
		if (w > LINE_LEN) w = LINE_LEN;
		h = height_reg;
		if (h < mcc_pkg::MIN_DIM) h = mcc_pkg::MIN_DIM;
		c = (col_pos >= LINE_LEN) ? LINE_LEN - 1 : col_pos;
		r = row_pos;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 2; j++)
				for (int ch = 0; ch < 3; ch++)
					win[i][j][ch] = win[i][j + 1][ch];
		for (int ch = 0; ch < 3; ch++) begin
			win[0][2][ch]    = row_prev2[c][ch];
			win[1][2][ch]    = row_prev[c][ch];
			win[2][2][ch]    = px[ch];
			row_prev2[c][ch] = row_prev[c][ch];
			row_prev[c][ch]  = px[ch];
		end
		if (r >= 2 && c >= 2) begin
			acc = 0;
			for (int ch = 0; ch < 3; ch++)
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						acc += longint'(win[i][j][ch]) * longint'(coeff[ch * 9 + i * 3 + j]);
			res.sum  = acc[mcc_pkg::SUM_BITS-1:0];
			res.col  = mcc_pkg::OUT_COL_BITS'(c - 2);
			res.row  = mcc_pkg::OUT_ROW_BITS'(r - 2);
			res.last = (r >= h - 1) && (c >= w - 1);
			owed_sums.push_back(res);
		end
		if (c >= w - 1) begin
			col_pos = 0;
			row_pos = (r >= h - 1) ? 0 : ((r + 1) & 16'hFFFF);
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic check_result();
		conv_out_t want;
		if (owed_sums.size() == 0) begin
			report_mismatch($sformatf("result with nothing owed: sum %0d col %0d row %0d",
				conv_sum, out_col, out_row));
		end else begin
			want = owed_sums.pop_front();
			if (conv_sum !== want.sum)
				report_mismatch($sformatf("conv_sum at row %0d col %0d: got %0d, want %0d",
					want.row, want.col, conv_sum, want.sum));
			if (out_col !== want.col)
				report_mismatch($sformatf("out_col: got %0d, want %0d", out_col, want.col));
			if (out_row !== want.row)
				report_mismatch($sformatf("out_row: got %0d, want %0d", out_row, want.row));
			if (frame_last !== want.last)
				report_mismatch($sformatf("frame_last at row %0d col %0d: got %b, want %b",
					want.row, want.col, frame_last, want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mcc_pkg::REG_IMAGE_WIDTH)
					width_reg = cfg_data[mcc_pkg::IMG_W_BITS-1:0];
				else if (cfg_index == mcc_pkg::REG_IMAGE_HEIGHT)
					height_reg = cfg_data[mcc_pkg::IMG_H_BITS-1:0];
			end
			if (in_valid && in_ready) begin
				if (func == mcc_pkg::FUNC_WEIGHT) begin
					if (weight_index < mcc_pkg::NUM_WEIGHTS)
						coeff[weight_index] = weight_value;
				end else begin
					slide_window(sample_ch0, sample_ch1, sample_ch2);
				end
			end
			if (end_check && !leftover_done) begin
				if (owed_sums.size() != 0)
					report_mismatch($sformatf("%0d results never arrived", owed_sums.size()));
				leftover_done = 1'b1;
			end
		end
		pending = owed_sums.size();
	end

endmodule

>>> test/multichannel_conv3x3_valid_top_tb.sv
`timescale 1ns / 1ps
// multichannel_conv3x3_valid_top_tb: stimulus and verdict for the 3x3 multichannel convolution
// drives u_top beside mcc_conv_checker, which predicts and compares; uses mcc_pkg
module multichannel_conv3x3_valid_top_tb;

	// idling patterns applied per phase
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// input channel, all driven to known values from time zero
	logic                                   in_valid     = 1'b0;
	logic                                   in_ready;
	logic                                   func         = mcc_pkg::FUNC_PIXEL;
	logic [mcc_pkg::WIDX_BITS-1:0]          weight_index = '0;
	logic signed [mcc_pkg::WEIGHT_BITS-1:0] weight_value = '0;
	logic signed [15:0]                     sample_ch0   = '0;
	logic signed [15:0]                     sample_ch1   = '0;
	logic signed [15:0]                     sample_ch2   = '0;

	// result channel
	logic                                   out_valid;
	logic                                   out_ready    = 1'b0;
	logic signed [mcc_pkg::SUM_BITS-1:0]    conv_sum;
	logic [mcc_pkg::OUT_COL_BITS-1:0]       out_col;
	logic [mcc_pkg::OUT_ROW_BITS-1:0]       out_row;
	logic                                   frame_last;

	// register write channel
	logic                                   cfg_valid    = 1'b0;
	logic                                   cfg_ready;
	logic [mcc_pkg::CFG_IDX_BITS-1:0]       cfg_index    = mcc_pkg::REG_IMAGE_WIDTH;
	logic [mcc_pkg::CFG_DATA_BITS-1:0]      cfg_data     = '0;

	logic end_check = 1'b0;
	int   errors;
	int   pending;

	// percentages for the current phase
	int idle_pct  = 0;
	int stall_pct = 0;

	multichannel_conv3x3_valid_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.weight_index (weight_index),
		.weight_value (weight_value),
		.sample_ch0   (sample_ch0),
		.sample_ch1   (sample_ch1),
		.sample_ch2   (sample_ch2),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.conv_sum     (conv_sum),
		.out_col      (out_col),
		.out_row      (out_row),
		.frame_last   (frame_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	mcc_conv_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.weight_index (weight_index),
		.weight_value (weight_value),
		.sample_ch0   (sample_ch0),
		.sample_ch1   (sample_ch1),
		.sample_ch2   (sample_ch2),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.conv_sum     (conv_sum),
		.out_col      (out_col),
		.out_row      (out_row),
		.frame_last   (frame_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.end_check    (end_check),
		.errors       (errors),
		.pending      (pending)
	);

	// 100 MHz clock
	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#2_000_000;
		$display("multichannel_conv3x3_valid_top_tb NOT OK");
		$finish;
	end

	// receiver side: random stall, redrawn every cycle, zero stall gives a steady ready
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				idle_pct  = 49;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				idle_pct  = 0;
				stall_pct = 49;
			end
			default: begin
				idle_pct  = 12;
				stall_pct = 12;
			end
		endcase
	endtask

	// one input transaction; valid is only dropped when an idle gap is actually taken,
	// so back-to-back transactions keep valid high across the edge
	task automatic send_item(input logic f, input logic [mcc_pkg::WIDX_BITS-1:0] idx,
		input logic signed [15:0] wv, input logic signed [15:0] s0, s1, s2);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		weight_index <= idx;
		weight_value <= wv;
		sample_ch0   <= s0;
		sample_ch1   <= s1;
		sample_ch2   <= s2;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// weight load with junk on the sample fields, which the block must ignore
	task automatic load_weight(input logic [mcc_pkg::WIDX_BITS-1:0] idx,
		input logic signed [15:0] wv);
		send_item(mcc_pkg::FUNC_WEIGHT, idx, wv, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// pixel with junk on the weight fields
	task automatic send_pixel(input logic signed [15:0] s0, s1, s2);
		send_item(mcc_pkg::FUNC_PIXEL, 5'($urandom), 16'($urandom), s0, s1, s2);
	endtask

	// mostly random, with the corners of the q1.15 range mixed in
	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(7))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			2:       return 16'sh0000;
			3:       return -16'sd1;
			default: return 16'($urandom);
		endcase
	endfunction

	// let every owed result come out, then cover pixels and weight loads still in the pipe
	task automatic drain_pipe();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (pending != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (16) @(posedge clk);
	endtask

	// both registers, one transaction each; valid stays high between the two
	task automatic write_dims(input logic [15:0] w_data, input logic [15:0] h_data);
		cfg_valid <= 1'b1;
		cfg_index <= mcc_pkg::REG_IMAGE_WIDTH;
		cfg_data  <= w_data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_index <= mcc_pkg::REG_IMAGE_HEIGHT;
		cfg_data  <= h_data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// width with random junk above the seven register bits
	function automatic logic [15:0] width_word(input logic [6:0] w);
		return {9'($urandom), w};
	endfunction

	initial begin
		logic [15:0] w_data;
		logic [15:0] h_data;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling, 3x3 frames so each frame gives exactly one result
		set_idling(IDLE_NONE);
		write_dims(width_word(7'd3), 16'd3);

		// every weight at the most negative value, then loads to indexes past the table
		for (int k = 0; k < mcc_pkg::NUM_WEIGHTS; k++)
			load_weight(5'(k), 16'sh8000);
		load_weight(5'd27, 16'sh7fff);
		load_weight(5'd31, 16'sh1234);

		// most negative times most negative: largest positive sum
		repeat (9) send_pixel(16'sh8000, 16'sh8000, 16'sh8000);
		// most positive samples against most negative weights: most negative sum
		repeat (9) send_pixel(16'sh7fff, 16'sh7fff, 16'sh7fff);

		// fresh weights from the corner mix, then a frame of mixed corners
		for (int k = 0; k < mcc_pkg::NUM_WEIGHTS; k++)
			load_weight(5'(k), pick_sample());
		repeat (9) send_pixel(pick_sample(), pick_sample(), pick_sample());

		// random phases; counters carry over, so a new geometry can land mid-frame
		for (int ph = 0; ph < 8; ph++) begin
			drain_pipe();
			case (ph)
				0: begin
					w_data = width_word(7'd64);
					h_data = 16'd3;
				end
				1: begin
					w_data = width_word(7'd5);
					h_data = 16'hFFFF;
				end
				2: begin
					// both below the minimum, clamped to three
					w_data = width_word(7'd0);
					h_data = 16'd0;
				end
				3: begin
					// width far above the line store, height two short of the minimum
					w_data = width_word(7'd127);
					h_data = 16'd1;
				end
				4: begin
					w_data = width_word(7'($urandom_range(64, 3)));
					h_data = 16'($urandom_range(12, 3));
				end
				5: begin
					w_data = width_word(7'd2);
					h_data = 16'd2;
				end
				6: begin
					w_data = width_word(7'd65);
					h_data = 16'($urandom_range(12, 3));
				end
				default: begin
					w_data = width_word(7'd3);
					h_data = 16'd3;
				end
			endcase
			write_dims(w_data, h_data);
			set_idling(idle_mode_t'(ph % 4));
			// mostly pixels; the odd weight load, some aimed past the table
			repeat (64) begin
				if ($urandom_range(9) == 0)
					load_weight(5'($urandom_range(31)), 16'($urandom));
				else
					send_pixel(pick_sample(), pick_sample(), pick_sample());
			end
		end

		// wind down: everything owed must arrive, then look for leftovers
		drain_pipe();
		stall_pct = 0;
		end_check <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (errors == 0)
			$display("multichannel_conv3x3_valid_top_tb OK");
		else
			$display("multichannel_conv3x3_valid_top_tb NOT OK");
		$finish;
	end

endmodule
